// ===== design/mgmt_session_lease_controller_defines.svh =====
// assertion macros for the session lease controller
`ifndef MGMT_SESSION_LEASE_CONTROLLER_DEFINES_SVH
`define MGMT_SESSION_LEASE_CONTROLLER_DEFINES_SVH
`ifndef ASSERT_OFF
`define MSLC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MSLC_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MSLC_ASSERT(label, clk, rst_n, prop, msg)
`define MSLC_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== design/mslc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mslc_pkg
// shared types and codes of the session lease controller
// ----------------------------------------------------------------------------
package mslc_pkg;
	localparam int unsigned DivDefault = 2;
	localparam int unsigned OpStateReset = 8;

	typedef enum logic [2:0] {
		OP_HELLO = 3'd0, OP_MGMT = 3'd1, OP_HB_QUERY = 3'd2, OP_HB_SENT = 3'd3,
		OP_PD_SENT = 3'd4, OP_TAKE_SEQ = 3'd5, OP_RESET = 3'd6, OP_NONE = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0, MODE_DISCOVERED = 3'd1, MODE_SESSION = 3'd2,
		MODE_OP = 3'd3, MODE_FAULT = 3'd4
	} mode_t;

	localparam logic [0:0] CFG_DIVISOR = 1'b0;
	localparam logic [0:0] CFG_OP_STATE = 1'b1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_LEN = 2'd1;
	localparam logic [1:0] ST_UNEXPECTED = 2'd2;
	localparam logic [1:0] ST_PEER_ERR = 2'd3;

	localparam logic [2:0] EK_NONE = 3'd0;
	localparam logic [2:0] EK_BAD_LEN = 3'd1;
	localparam logic [2:0] EK_SERVICE = 3'd2;
	localparam logic [2:0] EK_MESSAGE = 3'd3;
	localparam logic [2:0] EK_PEER = 3'd4;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [63:0] now_us;
		logic [31:0] process_seq;
		logic [47:0] src_mac;
		logic [15:0] device_state;
		logic [1:0]  reply_kind;
		logic [2:0]  header_flags;
		logic        length_ok;
		logic [31:0] session_number;
		logic [31:0] lease_granted_us;
		logic [15:0] peer_status_code;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  error_kind;
		logic [15:0] err_code;
		logic [3:0]  event_flags;
		logic [15:0] peer_state_out;
		logic        heartbeat_due;
		logic [31:0] sequence_out;
		logic [2:0]  ctrl_state;
		logic [31:0] session_out;
		logic        peer_valid;
		logic [47:0] mac_out;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture item, apply event, start divide if needed
		logic div_step;  // one restoring divide step
		logic finish;    // form result from divide
	} cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_last;
	} stat_t;
endpackage
`default_nettype wire

// ===== design/mslc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mslc_ctrl
// sequencer: accept, optional divide loop, hold result until taken
// ----------------------------------------------------------------------------
module mslc_ctrl import mslc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_fire,
	input  wire logic  out_fire,
	input  wire stat_t stat,
	output cmd_t       cmd,
	output logic       in_ready,
	output logic       out_valid
);
	typedef enum logic [1:0] {S_IDLE, S_DIV, S_FIN, S_OUT} state_t;
	state_t state_q;

	always_comb begin
		cmd.load = in_fire;
		cmd.div_step = (state_q == S_DIV);
		cmd.finish = (state_q == S_FIN);
	end
	assign in_ready = (state_q == S_IDLE) || (state_q == S_OUT && out_fire);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE, S_OUT: begin
					if (in_fire) begin
						if (stat.need_div) begin
							state_q <= S_DIV;
							out_valid <= 1'b0;
						end else begin
							state_q <= S_OUT;
							out_valid <= 1'b1;
						end
					end else if (out_fire) begin
						state_q <= S_IDLE;
						out_valid <= 1'b0;
					end
				end
				S_DIV: if (stat.div_last) state_q <= S_FIN;
				S_FIN: begin
					state_q <= S_OUT;
					out_valid <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== design/mslc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mslc_datapath
// session state, event decode and a bit-serial lease divider
// ----------------------------------------------------------------------------
module mslc_datapath import mslc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	input  wire item_t       item,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_idx,
	input  wire logic [15:0] cfg_data,
	output stat_t            stat,
	output result_t          res
);
	logic [7:0]  div_q;
	logic [15:0] opst_q;
	mode_t       mode_q;
	logic [47:0] mac_q;
	logic        seen_q;
	logic [15:0] pstate_q;
	logic [31:0] sess_q;
	logic [31:0] lease_q;
	logic [63:0] refresh_q;
	logic [31:0] pseq_q;
	logic [31:0] next_seq_q;

	// divider
	logic [31:0] quo_q;
	logic [7:0]  rem_q;
	logic [4:0]  cnt_q;
	logic [63:0] elapsed_q;
	logic [8:0]  trial;
	logic [7:0]  dv;
	logic        hb_pre;

	assign dv = (div_q == 8'd0) ? 8'(DivDefault) : div_q;
	assign trial = {rem_q, quo_q[31]} - {1'b0, dv};

	// query needs a divide only when the answer is not already settled
	assign hb_pre = (sess_q != 32'd0) && (mode_q == MODE_SESSION || mode_q == MODE_OP)
		&& (lease_q != 32'd0);
	assign stat.need_div = (op_t'(item.opcode) == OP_HB_QUERY) && hb_pre
		&& (refresh_q != 64'd0);
	assign stat.div_last = (cnt_q == 5'd31);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q <= 8'(DivDefault);
			opst_q <= 16'(OpStateReset);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_DIVISOR: div_q <= cfg_data[7:0];
				CFG_OP_STATE: opst_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			mac_q <= '0;
			seen_q <= 1'b0;
			pstate_q <= '0;
			sess_q <= '0;
			lease_q <= '0;
			refresh_q <= '0;
			pseq_q <= '0;
			next_seq_q <= 32'd1;
			cnt_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			elapsed_q <= '0;
			res <= '0;
		end else if (cmd.load) begin
			res.status <= ST_OK;
			res.error_kind <= EK_NONE;
			res.err_code <= '0;
			res.event_flags <= '0;
			res.heartbeat_due <= 1'b0;
			res.sequence_out <= '0;
			res.peer_state_out <= pstate_q;
			res.ctrl_state <= mode_q;
			res.session_out <= sess_q;
			res.peer_valid <= seen_q;
			res.mac_out <= mac_q;
			cnt_q <= '0;
			rem_q <= '0;
			quo_q <= lease_q;
			elapsed_q <= item.now_us - refresh_q;
			unique case (op_t'(item.opcode))
				OP_HELLO: begin
					if (!item.length_ok) begin
						res.status <= ST_BAD_LEN;
						res.error_kind <= EK_BAD_LEN;
					end else begin
						mac_q <= item.src_mac;
						seen_q <= 1'b1;
						pstate_q <= item.device_state;
						mode_q <= MODE_DISCOVERED;
						res.mac_out <= item.src_mac;
						res.peer_valid <= 1'b1;
						res.peer_state_out <= item.device_state;
						res.ctrl_state <= MODE_DISCOVERED;
						res.event_flags <= 4'b0001;
					end
				end
				OP_MGMT: begin
					priority if (!item.header_flags[0]) begin
						res.status <= ST_UNEXPECTED;
						res.error_kind <= EK_SERVICE;
					end else if (!item.header_flags[1]) begin
						res.status <= ST_UNEXPECTED;
						res.error_kind <= EK_MESSAGE;
					end else if (item.header_flags[2] || item.reply_kind < 2'd2) begin
						if (!item.length_ok) begin
							res.status <= ST_BAD_LEN;
							res.error_kind <= EK_BAD_LEN;
						end else if (item.header_flags[2]) begin
							mode_q <= MODE_FAULT;
							res.ctrl_state <= MODE_FAULT;
							res.status <= ST_PEER_ERR;
							res.error_kind <= EK_PEER;
							res.err_code <= item.peer_status_code;
						end else if (item.reply_kind == 2'd0) begin
							sess_q <= item.session_number;
							lease_q <= item.lease_granted_us;
							pstate_q <= item.device_state;
							mode_q <= MODE_SESSION;
							res.session_out <= item.session_number;
							res.peer_state_out <= item.device_state;
							res.ctrl_state <= MODE_SESSION;
							res.event_flags <= 4'b0010;
						end else begin
							pstate_q <= item.device_state;
							res.peer_state_out <= item.device_state;
							if (item.device_state == opst_q) begin
								mode_q <= MODE_OP;
								res.ctrl_state <= MODE_OP;
								res.event_flags <= 4'b1100;
							end else begin
								res.event_flags <= 4'b0100;
							end
						end
					end else begin
						res.status <= ST_UNEXPECTED;
						res.error_kind <= EK_MESSAGE;
					end
				end
				OP_HB_QUERY: res.heartbeat_due <= hb_pre;
				OP_HB_SENT: refresh_q <= item.now_us;
				OP_PD_SENT: begin
					pseq_q <= item.process_seq;
					refresh_q <= item.now_us;
				end
				OP_TAKE_SEQ: begin
					res.sequence_out <= next_seq_q;
					next_seq_q <= (next_seq_q == '1) ? 32'd1 : next_seq_q + 32'd1;
				end
				OP_RESET: begin
					mode_q <= MODE_IDLE;
					mac_q <= '0;
					seen_q <= 1'b0;
					pstate_q <= '0;
					sess_q <= '0;
					lease_q <= '0;
					refresh_q <= '0;
					pseq_q <= '0;
					next_seq_q <= 32'd1;
					res.peer_state_out <= '0;
					res.ctrl_state <= MODE_IDLE;
					res.session_out <= '0;
					res.peer_valid <= 1'b0;
					res.mac_out <= '0;
				end
				OP_NONE: ;
				default: ;
			endcase
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 5'd1;
			if (!trial[8]) begin
				rem_q <= trial[7:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[6:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end else if (cmd.finish) begin
			// interval of zero counts as one
			res.heartbeat_due <= (elapsed_q >= {32'd0, quo_q}) && (elapsed_q != 64'd0
				|| quo_q != 32'd0);
		end
	end

	// last process sequence is kept but not reported
	logic unused_pseq;
	assign unused_pseq = ^pseq_q;
endmodule
`default_nettype wire

// ===== design/mgmt_session_lease_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mgmt_session_lease_controller
// management session and lease controller, one result word per event word
// ----------------------------------------------------------------------------
// most events: result registered on accept; a heartbeat query that divides
// first runs the divide, a 32-step restoring loop, one quotient bit per cycle
// throughput: a new word each cycle the result is taken, none while a query divides
// reset: arst_n clears session state; config returns to divisor 2, op state 8
`include "mgmt_session_lease_controller_defines.svh"
module mgmt_session_lease_controller import mslc_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [0:0]   cfg_idx,
	input  wire logic [15:0]  cfg_data,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// opcode, now_us, process_seq, src_mac, device_state, reply_kind,
	// header_flags, length_ok, session_number, lease_granted_us, peer_status_code
	input  wire logic [255:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// status, error_kind, err_code, event_flags, peer_state_out, heartbeat_due,
	// sequence_out, ctrl_state, session_out, peer_valid, mac_out
	output logic [159:0]      m_tdata
);
	item_t   item;
	result_t res;
	cmd_t    cmd;
	stat_t   stat;
	logic    in_fire, out_fire;
	logic    unused_pad;

	assign item.opcode           = s_tdata[2:0];
	assign item.now_us           = s_tdata[66:3];
	assign item.process_seq      = s_tdata[98:67];
	assign item.src_mac          = s_tdata[146:99];
	assign item.device_state     = s_tdata[162:147];
	assign item.reply_kind       = s_tdata[164:163];
	assign item.header_flags     = s_tdata[167:165];
	assign item.length_ok        = s_tdata[168];
	assign item.session_number   = s_tdata[200:169];
	assign item.lease_granted_us = s_tdata[232:201];
	assign item.peer_status_code = s_tdata[248:233];
	assign unused_pad = ^s_tdata[255:249];

	assign m_tdata = {2'b0, res.mac_out, res.peer_valid, res.session_out, res.ctrl_state,
		res.sequence_out, res.heartbeat_due, res.peer_state_out, res.event_flags,
		res.err_code, res.error_kind, res.status};

	assign in_fire  = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;

	mslc_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .out_fire, .stat, .cmd,
		.in_ready(s_tready), .out_valid(m_tvalid)
	);

	mslc_datapath u_dp (
		.clk, .arst_n, .cmd, .item, .cfg_we, .cfg_idx, .cfg_data, .stat, .res
	);

	`MSLC_ASSERT(a_no_accept_busy, clk, arst_n, cmd.div_step |-> !s_tready, "accept during divide")
	`MSLC_ASSERT(a_hold_result, clk, arst_n, (m_tvalid && !m_tready) |=> $stable(m_tdata), "result changed while stalled")
	`MSLC_ASSERT(a_div_finish, clk, arst_n, (cmd.div_step && stat.div_last) |=> cmd.finish, "divide did not finish")
	`MSLC_ASSERT(a_no_accept_stalled, clk, arst_n, (m_tvalid && !m_tready) |-> !s_tready, "accept while result waits")
endmodule
`default_nettype wire

// ===== test/mgmt_session_lease_controller_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgmt_session_lease_controller_tb
// drives event words through the session lease controller under changing
// idle and stall patterns and register settings, predicts each result word
// and compares it field by field in arrival order
// ----------------------------------------------------------------------------
module mgmt_session_lease_controller_tb;
	import mslc_pkg::*;

	localparam int unsigned CycleLimit = 1000000;
	localparam int unsigned DrainCycles = 40;

	class lease_scoreboard;
		logic [7:0]  divisor;
		logic [15:0] op_code;
		mode_t       mode;
		logic [47:0] peer_address;
		logic        peer_seen;
		logic [15:0] peer_state;
		logic [31:0] sess_id;
		logic [31:0] lease_time;
		logic [63:0] last_refresh;
		logic [31:0] last_pd_seq;
		logic [31:0] next_seq;
		result_t     pending[$];
		int          errors;

		function new();
			divisor = DivDefault;
			op_code = OpStateReset;
			errors = 0;
			clear();
		endfunction

		function void clear();
			mode = MODE_IDLE;
			peer_address = '0;
			peer_seen = 1'b0;
			peer_state = '0;
			sess_id = '0;
			lease_time = '0;
			last_refresh = '0;
			last_pd_seq = '0;
			next_seq = 32'd1;
		endfunction

		function logic [63:0] interval();
			logic [63:0] d;
			logic [63:0] iv;
			d = (divisor == 8'd0) ? 64'(DivDefault) : 64'(divisor);
			iv = 64'(lease_time) / d;
			return (iv == 0) ? 64'd1 : iv;
		endfunction

		function void note(item_t it);
			result_t r;
			r = '0;
			case (op_t'(it.opcode))
				OP_HELLO: begin
					if (!it.length_ok) begin
						r.status = ST_BAD_LEN;
						r.error_kind = EK_BAD_LEN;
					end else begin
						peer_address = it.src_mac;
						peer_seen = 1'b1;
						peer_state = it.device_state;
						mode = MODE_DISCOVERED;
						r.event_flags = 4'b0001;
					end
				end
				OP_MGMT: begin
					if (!it.header_flags[0]) begin
						r.status = ST_UNEXPECTED;
						r.error_kind = EK_SERVICE;
					end else if (!it.header_flags[1]) begin
						r.status = ST_UNEXPECTED;
						r.error_kind = EK_MESSAGE;
					end else if (it.reply_kind > 2'd1 && !it.header_flags[2]) begin
						r.status = ST_UNEXPECTED;
						r.error_kind = EK_MESSAGE;
					end else if (!it.length_ok) begin
						r.status = ST_BAD_LEN;
						r.error_kind = EK_BAD_LEN;
					end else if (it.header_flags[2]) begin
						mode = MODE_FAULT;
						r.status = ST_PEER_ERR;
						r.error_kind = EK_PEER;
						r.err_code = it.peer_status_code;
					end else if (it.reply_kind == 2'd0) begin
						sess_id = it.session_number;
						lease_time = it.lease_granted_us;
						peer_state = it.device_state;
						mode = MODE_SESSION;
						r.event_flags = 4'b0010;
					end else begin
						peer_state = it.device_state;
						r.event_flags = 4'b0100;
						if (it.device_state == op_code) begin
							mode = MODE_OP;
							r.event_flags = 4'b1100;
						end
					end
				end
				OP_HB_QUERY: begin
					if (sess_id != 0 && (mode == MODE_SESSION || mode == MODE_OP)
							&& lease_time != 0)
						r.heartbeat_due = (last_refresh == 0) ||
							((it.now_us - last_refresh) >= interval());
				end
				OP_HB_SENT: last_refresh = it.now_us;
				OP_PD_SENT: begin
					last_pd_seq = it.process_seq;
					last_refresh = it.now_us;
				end
				OP_TAKE_SEQ: begin
					r.sequence_out = next_seq;
					next_seq = next_seq + 1;
					if (next_seq == 0)
						next_seq = 32'd1;
				end
				OP_RESET: clear();
				default: ;
			endcase
			r.peer_state_out = peer_state;
			r.ctrl_state = mode;
			r.session_out = sess_id;
			r.peer_valid = peer_seen;
			r.mac_out = peer_address;
			pending.push_back(r);
		endfunction

		function void check(result_t a);
			result_t e;
			string bad;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result word %p", a);
				return;
			end
			e = pending.pop_front();
			bad = "";
			if (a.status !== e.status) bad = {bad, " status"};
			if (a.error_kind !== e.error_kind) bad = {bad, " error_kind"};
			if (a.err_code !== e.err_code) bad = {bad, " err_code"};
			if (a.event_flags !== e.event_flags) bad = {bad, " event_flags"};
			if (a.peer_state_out !== e.peer_state_out) bad = {bad, " peer_state_out"};
			if (a.heartbeat_due !== e.heartbeat_due) bad = {bad, " heartbeat_due"};
			if (a.sequence_out !== e.sequence_out) bad = {bad, " sequence_out"};
			if (a.ctrl_state !== e.ctrl_state) bad = {bad, " ctrl_state"};
			if (a.session_out !== e.session_out) bad = {bad, " session_out"};
			if (a.peer_valid !== e.peer_valid) bad = {bad, " peer_valid"};
			if (a.mac_out !== e.mac_out) bad = {bad, " mac_out"};
			if (bad != "") begin
				errors++;
				if (errors <= 10)
					$display("mismatch in%s\n  expected %p\n  actual   %p", bad, e, a);
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [0:0]   cfg_idx;
	logic [15:0]  cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [255:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [159:0] m_tdata;

	lease_scoreboard sb;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned cycles;
	result_t     got;

	mgmt_session_lease_controller uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("mgmt_session_lease_controller_tb NOT OK");
			$finish;
		end
	end

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle_pct);

	// unpack result word, first field in the low bits
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got.status = m_tdata[1:0];
			got.error_kind = m_tdata[4:2];
			got.err_code = m_tdata[20:5];
			got.event_flags = m_tdata[24:21];
			got.peer_state_out = m_tdata[40:25];
			got.heartbeat_due = m_tdata[41];
			got.sequence_out = m_tdata[73:42];
			got.ctrl_state = m_tdata[76:74];
			got.session_out = m_tdata[108:77];
			got.peer_valid = m_tdata[109];
			got.mac_out = m_tdata[157:110];
			sb.check(got);
		end
	end

	task automatic send_event(item_t it);
		int unsigned gap;
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, it.peer_status_code, it.lease_granted_us, it.session_number,
			it.length_ok, it.header_flags, it.reply_kind, it.device_state,
			it.src_mac, it.process_seq, it.now_us, it.opcode};
		do @(posedge clk); while (!s_tready);
		sb.note(it);
		if ($urandom_range(99) < send_idle_pct) begin
			gap = $urandom_range(1, 6);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_regs(logic [15:0] div_word, logic [15:0] op_word);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_DIVISOR;
		cfg_data <= div_word;
		sb.divisor = div_word[7:0];
		@(posedge clk);
		cfg_idx <= CFG_OP_STATE;
		cfg_data <= op_word;
		sb.op_code = op_word;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic item_t noise_item();
		item_t it;
		it.opcode = 3'($urandom_range(0, 7));
		it.now_us = {$urandom, $urandom};
		it.process_seq = $urandom;
		it.src_mac = {16'($urandom), $urandom};
		it.device_state = 16'($urandom);
		it.reply_kind = 2'($urandom_range(0, 3));
		it.header_flags = 3'($urandom_range(0, 7));
		it.length_ok = 1'($urandom_range(0, 1));
		it.session_number = $urandom;
		it.lease_granted_us = $urandom;
		it.peer_status_code = 16'($urandom);
		return it;
	endfunction

	// mostly well formed session traffic with random content
	function automatic item_t session_item();
		item_t it;
		int unsigned pick;
		logic [63:0] iv;
		it = noise_item();
		it.length_ok = ($urandom_range(99) < 95);
		pick = $urandom_range(99);
		if (pick < 8) begin
			it.opcode = OP_HELLO;
		end else if (pick < 32) begin
			it.opcode = OP_MGMT;
			it.header_flags = ($urandom_range(99) < 90) ? 3'b011 : 3'($urandom_range(0, 7));
			it.reply_kind = ($urandom_range(99) < 40) ? 2'd0 : 2'd1;
			if ($urandom_range(99) < 70)
				it.lease_granted_us = $urandom_range(0, 3000);
			if ($urandom_range(99) < 50)
				it.device_state = sb.op_code;
			if ($urandom_range(99) < 5)
				it.session_number = 32'd0;
		end else if (pick < 62) begin
			it.opcode = OP_HB_QUERY;
			iv = sb.interval();
			if ($urandom_range(99) < 80)
				it.now_us = sb.last_refresh + 64'($urandom_range(0, 32'(2 * iv + 2)))
					- 64'd1;
			if ($urandom_range(99) < 25)
				it.now_us = sb.last_refresh + iv - 64'($urandom_range(0, 1));
		end else if (pick < 74) begin
			it.opcode = OP_HB_SENT;
			if ($urandom_range(99) < 80)
				it.now_us = sb.last_refresh + 64'($urandom_range(1, 4000));
		end else if (pick < 84) begin
			it.opcode = OP_PD_SENT;
			if ($urandom_range(99) < 80)
				it.now_us = sb.last_refresh + 64'($urandom_range(1, 4000));
		end else if (pick < 96) begin
			it.opcode = OP_TAKE_SEQ;
		end else if (pick < 98) begin
			it.opcode = OP_RESET;
		end else begin
			it.opcode = OP_NONE;
		end
		return it;
	endfunction

	function automatic item_t make(op_t op, logic [2:0] flags, logic [1:0] kind, logic ok,
			logic [63:0] now);
		item_t it;
		it = noise_item();
		it.opcode = op;
		it.header_flags = flags;
		it.reply_kind = kind;
		it.length_ok = ok;
		it.now_us = now;
		return it;
	endfunction

	task automatic run_directed();
		item_t it;
		send_event(make(OP_RESET, 3'b000, 2'd0, 1'b1, 64'd0));
		send_event(make(OP_HB_QUERY, 3'b011, 2'd0, 1'b1, 64'd5));
		send_event(make(OP_HELLO, 3'b000, 2'd0, 1'b0, 64'd0));
		it = make(OP_HELLO, 3'b000, 2'd0, 1'b1, 64'd0);
		it.src_mac = '1;
		it.device_state = '1;
		send_event(it);
		send_event(make(OP_MGMT, 3'b110, 2'd0, 1'b1, 64'd0));
		send_event(make(OP_MGMT, 3'b101, 2'd0, 1'b1, 64'd0));
		send_event(make(OP_MGMT, 3'b111, 2'd0, 1'b0, 64'd0));
		send_event(make(OP_MGMT, 3'b011, 2'd3, 1'b1, 64'd0));
		send_event(make(OP_MGMT, 3'b011, 2'd2, 1'b0, 64'd0));
		send_event(make(OP_MGMT, 3'b011, 2'd0, 1'b0, 64'd0));
		send_event(make(OP_MGMT, 3'b011, 2'd1, 1'b0, 64'd0));
		it = make(OP_MGMT, 3'b011, 2'd0, 1'b1, 64'd0);
		it.session_number = '1;
		it.lease_granted_us = '1;
		send_event(it);
		send_event(make(OP_HB_QUERY, 3'b011, 2'd0, 1'b1, 64'd1));
		send_event(make(OP_HB_SENT, 3'b000, 2'd0, 1'b1, 64'hFFFF_FFFF_FFFF_FF00));
		send_event(make(OP_HB_QUERY, 3'b000, 2'd0, 1'b1, 64'd0));
		it = make(OP_PD_SENT, 3'b000, 2'd0, 1'b1, 64'd100);
		it.process_seq = '1;
		send_event(it);
		send_event(make(OP_HB_QUERY, 3'b000, 2'd0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF));
		it = make(OP_MGMT, 3'b011, 2'd1, 1'b1, 64'd0);
		it.device_state = sb.op_code;
		send_event(it);
		send_event(make(OP_MGMT, 3'b011, 2'd1, 1'b1, 64'd0));
		send_event(make(OP_TAKE_SEQ, 3'b000, 2'd0, 1'b1, 64'd0));
		send_event(make(OP_TAKE_SEQ, 3'b000, 2'd0, 1'b1, 64'd0));
		send_event(make(OP_NONE, 3'b000, 2'd0, 1'b1, 64'd0));
		it = make(OP_MGMT, 3'b111, 2'd1, 1'b1, 64'd0);
		it.peer_status_code = '1;
		send_event(it);
		send_event(make(OP_HB_QUERY, 3'b000, 2'd0, 1'b1, 64'd0));
		send_event(make(OP_RESET, 3'b000, 2'd0, 1'b1, 64'd0));
	endtask

	task automatic run_random(int unsigned count, bit hold_off);
		for (int unsigned i = 0; i < count; i++) begin
			if (hold_off && i == count / 2)
				wait_idle();
			send_event(($urandom_range(99) < 80) ? session_item() : noise_item());
		end
	endtask

	initial begin
		sb = new();
		cycles = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = CFG_DIVISOR;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		wait_idle();
		write_regs(16'h0001, 16'h0000);
		run_random(330, 1'b0);

		wait_idle();
		send_idle_pct = 53;
		write_regs(16'hA5FF, 16'hFFFF);
		run_random(330, 1'b1);

		wait_idle();
		send_idle_pct = 0;
		recv_idle_pct = 53;
		// zero divisor falls back to the default
		write_regs(16'h3C00, 16'h0008);
		run_random(330, 1'b0);

		wait_idle();
		send_idle_pct = 28;
		recv_idle_pct = 28;
		write_regs(16'($urandom_range(3, 254)), 16'($urandom_range(0, 15)));
		run_random(330, 1'b0);

		wait_idle();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("mgmt_session_lease_controller_tb OK");
		else
			$display("mgmt_session_lease_controller_tb NOT OK");
		$finish;
	end
endmodule
